@@ design/fpfl_pkg.sv @@
`default_nettype none

package fpfl_pkg;

    // list geometry
    localparam int CPUS        = 8;
    localparam int CPU_W       = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int MAX_PAGES   = 32768;
    localparam int IDX_W       = $clog2(MAX_PAGES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int OP_W     = 2;
    localparam int CPU_ID_W = 3;
    localparam int PAGE_W   = 22;
    localparam int TOP_W    = 23;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 23;

    // opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SEED  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [CPU_ID_W-1:0] cpu_id;
        logic [PAGE_W-1:0]   page_number;
    } t_pfl_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   granted_page;
        logic [CPU_ID_W-1:0] served_by_cpu;
        logic                stolen;
    } t_pfl_out;

    // classified command from front to back
    typedef enum logic [1:0] {
        K_ALLOC,
        K_PUSH,
        K_BAD,
        K_NOP
    } t_pfl_kind;

    typedef struct packed {
        t_pfl_kind        kind;
        logic [CPU_W-1:0] cpu;
        logic [IDX_W-1:0] idx;
    } t_pfl_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_pfl_bstate;

endpackage

`default_nettype wire

@@ design/fpfl_front.sv @@
`default_nettype none

module fpfl_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  fpfl_pkg::t_pfl_in           i_in,
    input  logic [fpfl_pkg::PAGE_W-1:0] i_lowest_page,
    input  logic [fpfl_pkg::TOP_W-1:0]  i_top_page,
    input  logic                        i_full,
    output logic                        o_push,
    output fpfl_pkg::t_pfl_cmd          o_cmd
);
    import fpfl_pkg::*;

    logic [PAGE_W-1:0] w_diff;
    logic              w_in_range;
    logic [CPU_W-1:0]  w_cpu;
    logic [CPU_W-1:0]  r_seed_cpu;
    logic [CPU_W-1:0]  n_seed_cpu;

    // range check and table index
    assign w_diff     = i_in.page_number - i_lowest_page;
    assign w_in_range = (i_in.page_number >= i_lowest_page)
                     && ({1'b0, i_in.page_number} < i_top_page)
                     && (w_diff < PAGE_W'(MAX_PAGES));
    assign w_cpu      = i_in.cpu_id[CPU_W-1:0];

    // handshake toward the queue
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // classify the transaction
    always_comb begin
        o_cmd.kind = K_NOP;
        o_cmd.cpu  = '0;
        o_cmd.idx  = w_diff[IDX_W-1:0];
        case (i_in.opcode)
            OP_ALLOC: begin
                o_cmd.kind = K_ALLOC;
                o_cmd.cpu  = w_cpu;
            end
            OP_FREE: begin
                o_cmd.kind = w_in_range ? K_PUSH : K_BAD;
                o_cmd.cpu  = w_cpu;
            end
            OP_SEED: begin
                o_cmd.kind = w_in_range ? K_PUSH : K_BAD;
                o_cmd.cpu  = r_seed_cpu;
            end
            default: begin
                o_cmd.kind = K_NOP;
            end
        endcase
    end

    // round-robin seed pointer advances on a stored seed
    always_comb begin
        n_seed_cpu = r_seed_cpu;
        if (o_push && (i_in.opcode == OP_SEED) && w_in_range) begin
            n_seed_cpu = (r_seed_cpu == CPU_W'(CPUS - 1)) ? '0 : r_seed_cpu + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_cpu <= '0;
        end else begin
            r_seed_cpu <= n_seed_cpu;
        end
    end

endmodule

`default_nettype wire

@@ design/fpfl_queue.sv @@
`default_nettype none

module fpfl_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fpfl_pkg::t_pfl_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output fpfl_pkg::t_pfl_cmd o_cmd
);
    import fpfl_pkg::*;

    t_pfl_cmd          r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/fpfl_back.sv @@
`default_nettype none

module fpfl_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  fpfl_pkg::t_pfl_cmd          i_cmd,
    output logic                        o_cmd_pop,
    input  logic [fpfl_pkg::PAGE_W-1:0] i_lowest_page,
    output logic                        o_valid,
    input  logic                        i_ready,
    output fpfl_pkg::t_pfl_out          o_out
);
    import fpfl_pkg::*;

    // list heads and link table
    logic [IDX_W-1:0] r_head_index [CPUS];
    logic [CPUS-1:0]  r_head_valid;
    logic [IDX_W:0]   r_link_mem [MAX_PAGES];
    logic [IDX_W:0]   r_link_rd;

    t_pfl_bstate      r_state;
    t_pfl_bstate      n_state;
    logic [CPU_W-1:0] r_src;
    logic             r_stolen;
    logic [IDX_W-1:0] r_pop_idx;
    logic             r_out_valid;
    t_pfl_out         r_out;

    logic             w_out_free;
    logic             w_take;
    logic             w_any;
    logic [CPU_W-1:0] w_steal_cpu;
    logic [CPU_W-1:0] w_src;
    logic [CPU_W-1:0] w_sel_cpu;
    logic             w_alloc_hit;
    logic             w_mem_we;
    logic             w_mem_re;
    logic             w_finish;
    logic             w_load_out;
    t_pfl_out         w_res;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_take     = (r_state == BK_IDLE) && i_cmd_valid && w_out_free;
    assign o_cmd_pop  = w_take;
    assign o_valid    = r_out_valid;
    assign o_out      = r_out;

    // lowest-numbered non-empty list
    always_comb begin
        w_steal_cpu = '0;
        for (int j = CPUS - 1; j >= 0; j--) begin
            if (r_head_valid[j]) begin
                w_steal_cpu = CPU_W'(j);
            end
        end
    end

    assign w_any       = |r_head_valid;
    assign w_src       = r_head_valid[i_cmd.cpu] ? i_cmd.cpu : w_steal_cpu;
    assign w_sel_cpu   = (i_cmd.kind == K_ALLOC) ? w_src : i_cmd.cpu;
    assign w_alloc_hit = (i_cmd.kind == K_ALLOC) && w_any;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (w_take && w_alloc_hit) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // control outputs and result
    always_comb begin
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_finish   = 1'b0;
        w_load_out = 1'b0;
        w_res      = '0;
        case (r_state)
            BK_IDLE: begin
                w_mem_we   = w_take && (i_cmd.kind == K_PUSH);
                w_mem_re   = w_take && w_alloc_hit;
                w_load_out = w_take && !w_alloc_hit;
                case (i_cmd.kind)
                    K_ALLOC: begin
                        w_res.status = ST_OOM;
                    end
                    K_PUSH: begin
                        w_res.status        = ST_OK;
                        w_res.served_by_cpu = CPU_ID_W'(i_cmd.cpu);
                    end
                    K_BAD: begin
                        w_res.status = ST_BAD;
                    end
                    default: begin
                        w_res.status = ST_OK;
                    end
                endcase
            end
            BK_READ: begin
                w_finish             = w_out_free;
                w_load_out           = w_out_free;
                w_res.status         = ST_OK;
                w_res.granted_page   = i_lowest_page + PAGE_W'(r_pop_idx);
                w_res.served_by_cpu  = CPU_ID_W'(r_src);
                w_res.stolen         = r_stolen;
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // link table: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_link_mem[i_cmd.idx] <= {r_head_valid[i_cmd.cpu], r_head_index[i_cmd.cpu]};
        end
        if (w_mem_re) begin
            r_link_rd <= r_link_mem[r_head_index[w_sel_cpu]];
        end
    end

    // pop bookkeeping
    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_src     <= w_sel_cpu;
            r_stolen  <= !r_head_valid[i_cmd.cpu];
            r_pop_idx <= r_head_index[w_sel_cpu];
        end
    end

    // head indexes
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_head_index[i_cmd.cpu] <= i_cmd.idx;
        end else if (w_finish) begin
            r_head_index[r_src] <= r_link_rd[IDX_W-1:0];
        end
    end

    // head valid bits and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_state      <= BK_IDLE;
        end else begin
            r_state <= n_state;
            if (w_mem_we) begin
                r_head_valid[i_cmd.cpu] <= 1'b1;
            end else if (w_finish) begin
                r_head_valid[r_src] <= r_link_rd[IDX_W];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

@@ design/per_cpu_page_free_list_allocator.sv @@
// path: free, seed, bad address, out of memory and unused opcodes pass the command queue
//   and output register; an allocate that pops a page also passes the link table read
// throughput: 1 transaction per cycle for push-type work while results are taken;
//   an allocate hit holds the next command until the link table read lets the head move
// reset: synchronous active low; empties every list, clears the seed pointer, queue,
//   output register and configuration; the link table is not cleared
`default_nettype none

module per_cpu_page_free_list_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  fpfl_pkg::t_pfl_in               i_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output fpfl_pkg::t_pfl_out              o_out,
    input  logic                            i_cfg_we,
    input  logic [fpfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpfl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fpfl_pkg::*;

    logic [PAGE_W-1:0] r_lowest_page;
    logic [TOP_W-1:0]  r_top_page;

    logic     w_push;
    logic     w_full;
    t_pfl_cmd w_front_cmd;
    logic     w_q_valid;
    logic     w_q_pop;
    t_pfl_cmd w_q_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest_page <= '0;
            r_top_page    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOWEST: r_lowest_page <= i_cfg_data[PAGE_W-1:0];
                CFG_TOP:    r_top_page    <= i_cfg_data[TOP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: accept and classify
    fpfl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in          (i_in),
        .i_lowest_page (r_lowest_page),
        .i_top_page    (r_top_page),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    // command queue
    fpfl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd)
    );

    // back: list operations and result register
    fpfl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_q_valid),
        .i_cmd         (w_q_cmd),
        .o_cmd_pop     (w_q_pop),
        .i_lowest_page (r_lowest_page),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out         (o_out)
    );

    // a failed transaction carries no page, list or steal flag
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.status != ST_OK))
        |-> ((o_out.granted_page == '0) && (o_out.served_by_cpu == '0) && !o_out.stolen))
        else $error("failed result carries nonzero fields");

    // a steal only happens on a successful allocate
    a_steal_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.stolen) |-> (o_out.status == ST_OK))
        else $error("stolen flag on a non-ok result");

    // nothing leaves the block right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // the queue only pops what it holds
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("back took a command from an empty queue");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfl_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;

    // predicts the allocator's lists and holds the results still owed
    class page_list_scoreboard;
        logic [IDX_W-1:0]  head_idx [CPUS];
        bit                head_vld [CPUS];
        logic [IDX_W-1:0]  link_idx [MAX_PAGES];
        bit                link_vld [MAX_PAGES];
        logic [CPU_W-1:0]  seed_ptr;
        logic [PAGE_W-1:0] lowest;
        logic [TOP_W-1:0]  top;
        t_pfl_out          owed_results[$];
        int                errors;

        function new();
            for (int c = 0; c < CPUS; c++) begin
                head_idx[c] = '0;
                head_vld[c] = 1'b0;
            end
            seed_ptr = '0;
            lowest   = '0;
            top      = '0;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_LOWEST: lowest = val[PAGE_W-1:0];
                CFG_TOP:    top    = val[TOP_W-1:0];
                default: ;
            endcase
        endfunction

        // maps a page number to its link table slot, 0 when unmanaged
        function bit page_slot(input logic [PAGE_W-1:0] page,
                               output logic [IDX_W-1:0] slot);
            int unsigned offset;
            slot = '0;
            if (page < lowest || {1'b0, page} >= top) return 1'b0;
            offset = page - lowest;
            if (offset >= MAX_PAGES) return 1'b0;
            slot = offset[IDX_W-1:0];
            return 1'b1;
        endfunction

        function bit lists_empty();
            for (int c = 0; c < CPUS; c++)
                if (head_vld[c]) return 1'b0;
            return 1'b1;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // applies one accepted request to the lists and queues its result
        function t_pfl_out note_request(t_pfl_in item);
            t_pfl_out         res;
            logic [CPU_W-1:0] cpu;
            logic [CPU_W-1:0] src;
            logic [CPU_W-1:0] dst;
            logic [IDX_W-1:0] slot;
            bit               found;
            int               j;
            res = '0;
            cpu = CPU_W'(item.cpu_id % CPUS);
            case (item.opcode)
                OP_ALLOC: begin
                    // own list first, then the lowest-numbered cpu with pages
                    src   = cpu;
                    found = head_vld[cpu];
                    for (j = 0; j < CPUS; j++) begin
                        if (!found && j != cpu && head_vld[j]) begin
                            src        = CPU_W'(j);
                            found      = 1'b1;
                            res.stolen = 1'b1;
                        end
                    end
                    if (found) begin
                        slot          = head_idx[src];
                        head_idx[src] = link_idx[slot];
                        head_vld[src] = link_vld[slot];
                        res.granted_page  = lowest + slot;
                        res.served_by_cpu = src;
                    end else begin
                        res.status = ST_OOM;
                    end
                end
                OP_FREE, OP_SEED: begin
                    if (page_slot(item.page_number, slot)) begin
                        dst = (item.opcode == OP_FREE) ? cpu : seed_ptr;
                        link_idx[slot] = head_idx[dst];
                        link_vld[slot] = head_vld[dst];
                        head_idx[dst]  = slot;
                        head_vld[dst]  = 1'b1;
                        res.served_by_cpu = dst;
                        if (item.opcode == OP_SEED) seed_ptr = CPU_W'((dst + 1) % CPUS);
                    end else begin
                        res.status = ST_BAD;
                    end
                end
                default: ;
            endcase
            owed_results.push_back(res);
            return res;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_pfl_out got);
            t_pfl_out want;
            if (owed_results.size() == 0) begin
                $display("%0t: result with nothing outstanding, actual %h", $time, got);
                errors++;
            end else begin
                want = owed_results.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("granted_page", want.granted_page, got.granted_page);
                compare_field("served_by_cpu", want.served_by_cpu, got.served_by_cpu);
                compare_field("stolen", want.stolen, got.stolen);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_pfl_in               i_in;
    logic                  o_valid;
    logic                  i_ready;
    t_pfl_out              o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    page_list_scoreboard sb;
    bit                  listed_pages[int];
    bit                  idle_on     = 1'b1;
    bit                  calm_finish = 1'b0;
    bit                  long_hold   = 1'b0;
    int                  quiet_cycles = 0;

    per_cpu_page_free_list_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check each transaction, stall in bursts or one long hold
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) sb.check_result(o_out);
            if (long_hold) begin
                long_hold  = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // offer one request and hold it until it is accepted
    task automatic send_item(input t_pfl_in item, output t_pfl_out predicted);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= item;
        do @(posedge i_clk); while (!o_ready);
        predicted = sb.note_request(item);
    endtask

    // send a request and track which pages sit on a list
    task automatic issue(input logic [OP_W-1:0] op, input logic [CPU_ID_W-1:0] cpu,
                         input logic [PAGE_W-1:0] page);
        t_pfl_in  item;
        t_pfl_out res;
        item.opcode      = op;
        item.cpu_id      = cpu;
        item.page_number = page;
        send_item(item, res);
        if (res.status == ST_OK) begin
            if (op == OP_ALLOC) begin
                listed_pages.delete(int'(res.granted_page));
            end else if (op == OP_FREE || op == OP_SEED) begin
                listed_pages[int'(page)] = 1'b1;
            end
        end
    endtask

    // stop offering and wait for every owed result
    task automatic quiesce();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [PAGE_W-1:0] lo, input logic [TOP_W-1:0] tp);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LOWEST;
        i_cfg_data  <= CFG_DATA_W'(lo);
        @(posedge i_clk);
        i_cfg_index <= CFG_TOP;
        i_cfg_data  <= CFG_DATA_W'(tp);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(CFG_LOWEST, CFG_DATA_W'(lo));
        sb.set_reg(CFG_TOP, CFG_DATA_W'(tp));
    endtask

    // allocate until every list is empty
    task automatic drain_lists();
        while (!sb.lists_empty())
            issue(OP_ALLOC, CPU_ID_W'($urandom), PAGE_W'($urandom));
        listed_pages.delete();
    endtask

    // mostly well-formed alloc/free/seed traffic over a page window, some noise
    task automatic random_traffic(input int count, input int win_lo, input int win_hi,
                                  input bit allow_dup);
        logic [OP_W-1:0]     op;
        logic [CPU_ID_W-1:0] cpu;
        logic [PAGE_W-1:0]   page;
        logic [IDX_W-1:0]    slot;
        int                  roll;
        bit                  found;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0 && !calm_finish) idle_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            cpu  = CPU_ID_W'($urandom);
            page = PAGE_W'($urandom);
            if (roll < 10) begin
                op = OP_W'($urandom_range(0, 3));
                if (!allow_dup && (op == OP_FREE || op == OP_SEED) &&
                    sb.page_slot(page, slot) && listed_pages.exists(int'(page)))
                    op = OP_UNUSED;
            end else if (roll < 50) begin
                op = OP_ALLOC;
            end else begin
                op    = (roll < 82) ? OP_FREE : OP_SEED;
                found = 1'b0;
                for (int t = 0; t < 32 && !found; t++) begin
                    page  = PAGE_W'($urandom_range(win_hi, win_lo));
                    found = allow_dup || !listed_pages.exists(int'(page));
                end
                if (!found) op = OP_ALLOC;
            end
            // now and then wait for the block to empty before going on
            if (!calm_finish && $urandom_range(0, 79) == 0) quiesce();
            issue(op, cpu, page);
        end
    endtask

    initial begin : stimulus
        sb = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_LOWEST;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing managed after reset
        issue(OP_ALLOC, 3'd0, 22'd0);
        issue(OP_FREE, 3'd0, 22'd0);
        issue(OP_SEED, 3'd7, 22'h3FFFFF);
        issue(OP_UNUSED, 3'd7, 22'h3FFFFF);
        quiesce();

        // small window: bounds, round robin, own pops, steals, out of memory
        set_config(22'd1000, 23'd1064);
        issue(OP_ALLOC, 3'd3, 22'd0);
        issue(OP_FREE, 3'd0, 22'd999);
        issue(OP_FREE, 3'd0, 22'd1064);
        issue(OP_SEED, 3'd0, 22'h3FFFFF);
        issue(OP_FREE, 3'd0, 22'd1000);
        issue(OP_SEED, 3'd4, 22'd1063);
        issue(OP_SEED, 3'd4, 22'd1001);
        issue(OP_UNUSED, 3'd7, 22'h3FFFFF);
        issue(OP_FREE, 3'd7, 22'd1010);
        issue(OP_ALLOC, 3'd7, 22'd0);
        issue(OP_ALLOC, 3'd5, 22'd0);
        issue(OP_ALLOC, 3'd5, 22'd0);
        issue(OP_ALLOC, 3'd5, 22'd0);
        issue(OP_ALLOC, 3'd6, 22'd0);
        issue(OP_FREE, 3'd5, 22'd1005);
        issue(OP_FREE, 3'd5, 22'd1006);
        issue(OP_ALLOC, 3'd5, 22'd0);

        // receiver holds off long enough for the input side to back up
        long_hold = 1'b1;
        random_traffic(400, 996, 1067, 1'b0);

        // move lowest_page while pages are still listed, then pop them all
        if (sb.lists_empty()) issue(OP_SEED, 3'd0, 22'd1030);
        quiesce();
        set_config(22'd1003, 23'd1064);
        drain_lists();

        // whole page space, table size bounds the managed pages
        quiesce();
        set_config(22'd0, 23'h400000);
        random_traffic(300, 0, 40000, 1'b0);
        drain_lists();

        // single managed page at the very top
        quiesce();
        set_config(22'h3FFFFF, 23'h400000);
        random_traffic(120, 4194300, 4194303, 1'b0);
        drain_lists();

        // empty range, lowest above top
        quiesce();
        set_config(22'd5000, 23'd4000);
        random_traffic(40, 3990, 5010, 1'b0);

        // repeated frees let lists share and loop entries
        quiesce();
        set_config(22'd200, 23'd216);
        issue(OP_FREE, 3'd2, 22'd210);
        issue(OP_FREE, 3'd2, 22'd210);
        issue(OP_ALLOC, 3'd2, 22'd0);
        issue(OP_ALLOC, 3'd2, 22'd0);
        random_traffic(200, 196, 219, 1'b1);

        // closing stretch at full rate
        calm_finish = 1'b1;
        idle_on     = 1'b0;
        random_traffic(100, 196, 219, 1'b1);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
